### src/gray_histogram_bar_render_top_assert.svh
// ----------------------------------------------------------------------------
// Histogram block assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAY_HISTOGRAM_BAR_RENDER_TOP_ASSERT_SVH
`define GRAY_HISTOGRAM_BAR_RENDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GHBR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram assertion failed");
// Next-cycle implication.
`define GHBR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram assertion failed");
`else
`define GHBR_ASSERT_NOW(lbl, ante, cons)
`define GHBR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/ghbr_pkg.sv
// ----------------------------------------------------------------------------
// Histogram package
// Widths, opcodes and the command and status bundles shared by the modules.
// ----------------------------------------------------------------------------
package ghbr_pkg;

  localparam int MAX_PIXELS_LOG2 = 22;
  localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
  localparam int NUM_BINS        = 256;
  localparam int BIN_W           = 8;
  localparam int OP_W            = 2;
  localparam int PM_W            = 10;
  localparam int ROWS_W          = 8;
  localparam int NUM_W           = CNT_W + PM_W;
  localparam int STEP_W          = $clog2(PM_W);
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 24;

  localparam logic [CNT_W-1:0]  PIXEL_LIMIT     = CNT_W'(1) << MAX_PIXELS_LOG2;
  localparam logic [PM_W-1:0]   PER_MILLE_SCALE = PM_W'(1000);
  localparam logic [ROWS_W-1:0] ROWS_RESET      = ROWS_W'(100);

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic rd_en;     // read the bin store at the incoming address
    logic rd_pix;    // address from pixel_value rather than bin_index
    logic clear;
    logic drop;
    logic add_wr;
    logic mul_ld;
    logic div_step;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

### src/ghbr_ctrl.sv
// ----------------------------------------------------------------------------
// Histogram controller
// Sequences adds, clears and queries; one transaction in flight at a time.
// ----------------------------------------------------------------------------
module ghbr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic [ghbr_pkg::OP_W-1:0] opcode,
  output logic                  in_tready,
  input  ghbr_pkg::sts_t        sts,
  output ghbr_pkg::cmd_t        cmd
);
  import ghbr_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_pix = (opcode == OP_ADD);
          if (opcode == OP_ADD) begin
            if (sts.full) begin
              cmd.drop = 1'b1;
            end else begin
              state_nxt = ST_ADD;
            end
          end else if (opcode == OP_QUERY) begin
            state_nxt = ST_MUL;
          end else if (opcode == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end
        end
      end
      ST_ADD: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/ghbr_dp.sv
// ----------------------------------------------------------------------------
// Histogram datapath
// Bin store, total, overflow flag, share divider and the result register.
// ----------------------------------------------------------------------------
module ghbr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ghbr_pkg::cmd_t                cmd,
  output ghbr_pkg::sts_t                sts,
  input  logic [ghbr_pkg::BIN_W-1:0]    pixel_value,
  input  logic [ghbr_pkg::BIN_W-1:0]    bin_index,
  input  logic                          cfg_valid,
  input  logic [ghbr_pkg::ROWS_W-1:0]   cfg_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ghbr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import ghbr_pkg::*;

  logic [CNT_W-1:0]      mem [NUM_BINS];
  logic [NUM_BINS-1:0]   vld_r;
  logic [BIN_W-1:0]      addr_r;
  logic [BIN_W-1:0]      rd_addr;
  logic [CNT_W-1:0]      rd_data_r;
  logic                  rd_vld_r;
  logic [CNT_W-1:0]      cnt_cur;
  logic [CNT_W-1:0]      total_r;
  logic                  dropped_r;
  logic [ROWS_W-1:0]     rows_r;

  logic [NUM_W-1:0]      rem_r;
  logic [NUM_W-1:0]      den_r;
  logic [PM_W-1:0]       quot_r;
  logic [STEP_W-1:0]     step_r;

  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                  empty;
  logic [PM_W-1:0]       share;
  logic [ROWS_W-1:0]     black;

  assign rd_addr = cmd.rd_pix ? pixel_value : bin_index;
  assign cnt_cur = rd_vld_r ? rd_data_r : '0;

  // Bin store: one read at transaction accept, one write-back for an add.
  always_ff @(posedge clk) begin
    if (cmd.add_wr) begin
      mem[addr_r] <= cnt_cur + CNT_W'(1);
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      addr_r    <= rd_addr;
    end
  end

  // An entry that is not marked valid reads as zero, so a clear needs no sweep of the store.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      total_r   <= '0;
      dropped_r <= 1'b0;
      rows_r    <= ROWS_RESET;
    end else begin
      if (cmd.rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
      if (cmd.clear) begin
        vld_r     <= '0;
        total_r   <= '0;
        dropped_r <= 1'b0;
      end else begin
        if (cmd.drop) begin
          dropped_r <= 1'b1;
        end
        if (cmd.add_wr) begin
          vld_r[addr_r] <= 1'b1;
          total_r       <= total_r + CNT_W'(1);
        end
      end
      if (cfg_valid) begin
        rows_r <= cfg_data;
      end
    end
  end

  // Restoring division of count*1000 by the total, one quotient bit per cycle.
  // The share never exceeds 1000, so PM_W quotient bits are enough.
  always_ff @(posedge clk) begin
    if (cmd.mul_ld) begin
      rem_r  <= NUM_W'(cnt_cur) * NUM_W'(PER_MILLE_SCALE);
      den_r  <= NUM_W'(total_r) << (PM_W - 1);
      quot_r <= '0;
      step_r <= STEP_W'(PM_W - 1);
    end else if (cmd.div_step) begin
      if (rem_r >= den_r) begin
        rem_r  <= rem_r - den_r;
        quot_r <= {quot_r[PM_W-2:0], 1'b1};
      end else begin
        quot_r <= {quot_r[PM_W-2:0], 1'b0};
      end
      den_r  <= den_r >> 1;
      step_r <= step_r - STEP_W'(1);
    end
  end

  assign empty = (total_r == '0);
  assign share = empty ? '0 : quot_r;
  assign black = ({{(PM_W-ROWS_W){1'b0}}, rows_r} > share) ?
                 (rows_r - share[ROWS_W-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_data_r <= {{(OUT_DATA_W-PM_W-ROWS_W-2){1'b0}}, dropped_r, empty, black, share};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  assign sts.full     = (total_r >= PIXEL_LIMIT);
  assign sts.div_last = (step_r == '0);
  assign sts.out_free = !out_vld_r || out_tready;

endmodule

### src/gray_histogram_bar_render_top.sv
// ----------------------------------------------------------------------------
// Gray histogram with bar-chart query
// Counts 8-bit gray pixels into 256 bins and answers per-mille bin queries.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_*     in   opcode, pixel_value, bin_index
//  out_*    out  per_mille, black_from_row, empty_res, overflow
//  cfg_*    in   chart_rows
//
// An add reads the bin, then writes it back; a clear or an ignored opcode
// completes when it is accepted. A query reads the bin, multiplies by 1000,
// runs the one-bit-per-cycle divider, then loads the result register, and
// waits for that register while the output stalls.
// Reset clears the bin valid bits at once, so no sweep is needed.
// The result register lets a new transaction be accepted while a result waits.
// ----------------------------------------------------------------------------
`include "gray_histogram_bar_render_top_assert.svh"

module gray_histogram_bar_render_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // opcode[1:0], pixel_value[9:2], bin_index[17:10]
  input  logic [ghbr_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // per_mille[9:0], black_from_row[17:10], empty_res[18], overflow[19]
  output logic [ghbr_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ghbr_pkg::ROWS_W-1:0]       cfg_data    // chart_rows
);
  import ghbr_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  logic [OP_W-1:0]   opcode;
  logic [BIN_W-1:0]  pixel_value;
  logic [BIN_W-1:0]  bin_index;

  assign opcode      = in_tdata[OP_W-1:0];
  assign pixel_value = in_tdata[OP_W+BIN_W-1:OP_W];
  assign bin_index   = in_tdata[OP_W+2*BIN_W-1:OP_W+BIN_W];
  assign cfg_ready   = 1'b1;

  ghbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .opcode    (opcode),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ghbr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .pixel_value (pixel_value),
    .bin_index   (bin_index),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // A query keeps the input side closed while the divider runs.
  `GHBR_ASSERT_NXT(a_query_busy, in_tvalid && in_tready && opcode == OP_QUERY, !in_tready)
  // The share of one bin can never exceed the whole.
  `GHBR_ASSERT_NOW(a_share_range, out_tvalid, out_tdata[PM_W-1:0] <= PER_MILLE_SCALE)
  // An empty histogram reports a zero share.
  `GHBR_ASSERT_NOW(a_empty_zero, out_tvalid && out_tdata[PM_W+ROWS_W], out_tdata[PM_W-1:0] == '0)

endmodule

### tb/gray_histogram_bar_render_top_tb.sv
// ----------------------------------------------------------------------------
// Gray histogram bar-render testbench
// Sends add, query, clear and ignored commands with random gaps on both
// streams, mirrors the histogram in a local model and checks every query
// transaction field by field against it, across several chart heights.
// ----------------------------------------------------------------------------
module gray_histogram_bar_render_top_tb;
  import ghbr_pkg::*;

  localparam logic [OP_W-1:0] OP_IGNORED   = 2'd3;
  localparam int              DRAIN_CYCLES = 20;
  localparam int              CYCLE_LIMIT  = 500_000;

  typedef struct packed {
    logic [PM_W-1:0]   per_mille;
    logic [ROWS_W-1:0] black_from_row;
    logic              empty_res;
    logic              overflow;
  } bar_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data   = '0;

  // Local copy of the histogram state.
  logic [CNT_W-1:0]  hist_bins [NUM_BINS];
  logic [CNT_W-1:0]  hist_total;
  logic              hist_dropped;
  logic [ROWS_W-1:0] chart_rows;

  bar_result_t pending_bars[$];

  bit in_rush  = 1'b0;
  bit out_rush = 1'b0;

  int n_errors  = 0;
  int n_cmds    = 0;
  int n_queries = 0;
  int n_clears  = 0;
  int n_cfg     = 0;
  int n_results = 0;
  int cycle_count = 0;

  gray_histogram_bar_render_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL gray_histogram_bar_render_top");
      $finish;
    end
  end

  function automatic void clear_hist_model();
    for (int k = 0; k < NUM_BINS; k++) hist_bins[k] = '0;
    hist_total   = '0;
    hist_dropped = 1'b0;
  endfunction

  // Updates the model for one accepted command and queues any bar result.
  function automatic void histogram_apply(logic [OP_W-1:0] op, logic [7:0] pix,
                                          logic [7:0] bin);
    logic [63:0] share;
    bar_result_t res;
    case (op)
      OP_ADD: begin
        if (hist_total >= PIXEL_LIMIT) begin
          hist_dropped = 1'b1;
        end else begin
          hist_bins[pix] = hist_bins[pix] + 1'b1;
          hist_total     = hist_total + 1'b1;
        end
      end
      OP_QUERY: begin
        share = '0;
        if (hist_total != '0)
          share = (64'(hist_bins[bin]) * 64'(PER_MILLE_SCALE)) / 64'(hist_total);
        res.per_mille      = share[PM_W-1:0];
        res.black_from_row = (64'(chart_rows) > share) ? 8'(64'(chart_rows) - share)
                                                       : 8'd0;
        res.empty_res      = (hist_total == '0);
        res.overflow       = hist_dropped;
        pending_bars.push_back(res);
        n_queries++;
      end
      OP_CLEAR: begin
        clear_hist_model();
        n_clears++;
      end
      default: ;
    endcase
  endfunction

  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [7:0] pix,
                          input logic [7:0] bin);
    int gap;
    gap = in_rush ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, bin, pix, op};
    do @(posedge clk); while (!in_tready);
    histogram_apply(op, pix, bin);
    n_cmds++;
  endtask

  // Adds and clears give no result, so the extra drain wait after the queue empties covers them too.
  task automatic wait_bars_drained();
    in_tvalid <= 1'b0;
    while (pending_bars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_chart_rows(input logic [7:0] rows);
    wait_bars_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    chart_rows = rows;
    n_cfg++;
  endtask

  // Result side: a fresh stall is drawn for every transaction.
  initial begin
    int stall;
    forever begin
      stall = out_rush ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    bar_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bars.size() == 0) begin
        $error("unexpected result transaction, data %h", out_tdata);
        n_errors++;
      end else begin
        want = pending_bars.pop_front();
        n_results++;
        if (out_tdata[9:0] !== want.per_mille) begin
          $error("per_mille: expected %0d, got %0d", want.per_mille, out_tdata[9:0]);
          n_errors++;
        end
        if (out_tdata[17:10] !== want.black_from_row) begin
          $error("black_from_row: expected %0d, got %0d", want.black_from_row,
                 out_tdata[17:10]);
          n_errors++;
        end
        if (out_tdata[18] !== want.empty_res) begin
          $error("empty_res: expected %0b, got %0b", want.empty_res, out_tdata[18]);
          n_errors++;
        end
        if (out_tdata[19] !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_tdata[19]);
          n_errors++;
        end
      end
    end
  end

  task automatic test_empty_histogram();
    send_cmd(OP_QUERY, 8'hFF, 8'h00);
    send_cmd(OP_QUERY, 8'h00, 8'hFF);
    send_cmd(OP_IGNORED, 8'hFF, 8'hFF);
    send_cmd(OP_QUERY, 8'($urandom), 8'h5A);
  endtask

  task automatic test_add_and_query();
    send_cmd(OP_ADD, 8'h00, 8'hFF);
    send_cmd(OP_ADD, 8'hFF, 8'h00);
    send_cmd(OP_ADD, 8'hFF, 8'h3C);
    send_cmd(OP_ADD, 8'h80, 8'hFF);
    send_cmd(OP_QUERY, 8'hFF, 8'h00);
    send_cmd(OP_QUERY, 8'h00, 8'hFF);
    send_cmd(OP_QUERY, 8'h80, 8'h80);
    send_cmd(OP_QUERY, 8'h80, 8'h7F);
    // The ignored opcode must leave the counts alone.
    send_cmd(OP_IGNORED, 8'hFF, 8'($urandom));
    send_cmd(OP_QUERY, 8'($urandom), 8'hFF);
  endtask

  task automatic test_single_bin_and_clear();
    send_cmd(OP_CLEAR, 8'hFF, 8'hFF);
    repeat (3) send_cmd(OP_ADD, 8'h33, 8'($urandom));
    send_cmd(OP_QUERY, 8'hCC, 8'h33);
    send_cmd(OP_CLEAR, 8'h00, 8'h00);
    send_cmd(OP_QUERY, 8'h33, 8'h33);
  endtask

  task automatic test_chart_heights();
    logic [7:0] heights [3];
    heights = '{8'd255, 8'd1, 8'd0};
    foreach (heights[h]) begin
      write_chart_rows(heights[h]);
      send_cmd(OP_ADD, 8'h10, 8'h00);
      send_cmd(OP_QUERY, 8'h00, 8'h10);
      send_cmd(OP_QUERY, 8'h00, 8'h11);
    end
  endtask

  task automatic test_random_mix();
    logic [7:0] palette [4];
    logic [7:0] pix, bin;
    int         pick;
    bit         use_palette;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       write_chart_rows(8'd255);
        1:       write_chart_rows(8'd1);
        2:       write_chart_rows(8'd0);
        default: write_chart_rows(8'($urandom));
      endcase
      foreach (palette[p]) palette[p] = 8'($urandom);
      use_palette = (phase % 2 == 0);
      for (int i = 0; i < 300; i++) begin
        if (i % 50 == 0) begin
          in_rush  = ($urandom_range(0, 3) == 0);
          out_rush = ($urandom_range(0, 3) == 0);
        end
        pix  = (use_palette && $urandom_range(0, 3) != 0) ? palette[$urandom_range(0, 3)]
                                                          : 8'($urandom);
        bin  = ($urandom_range(0, 1) == 0) ? palette[$urandom_range(0, 3)] : 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 70)      send_cmd(OP_ADD, pix, bin);
        else if (pick < 93) send_cmd(OP_QUERY, pix, bin);
        else if (pick < 96) send_cmd(OP_CLEAR, pix, bin);
        else                send_cmd(OP_IGNORED, pix, bin);
      end
    end
    in_rush  = 1'b0;
    out_rush = 1'b0;
    write_chart_rows(ROWS_RESET);
  endtask

  initial begin
    clear_hist_model();
    chart_rows = ROWS_RESET;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_histogram();
    test_add_and_query();
    test_single_bin_and_clear();
    test_chart_heights();
    test_random_mix();

    wait_bars_drained();
    $display("Checked %0d query results from %0d commands (%0d queries, %0d clears).",
             n_results, n_cmds, n_queries, n_clears);
    $display("Chart height written %0d times, including zero, one and full height.",
             n_cfg);
    if (n_errors == 0) begin
      $display("PASS gray_histogram_bar_render_top");
    end else begin
      $display("FAIL gray_histogram_bar_render_top");
    end
    $finish;
  end

endmodule
